// File: rtl/lsoc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes of the laser scan obstacle check.
package lsoc_pkg;

    localparam int MAX_SCAN_POINTS = 4096;
    localparam int IDX_W = $clog2(MAX_SCAN_POINTS);
    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(MAX_SCAN_POINTS - 1);

    localparam logic [9:0] FRONT_CENTER_INDEX = 10'd540;
    localparam logic [12:0] HIT_LIMIT = 13'd4096;
    localparam logic [12:0] BLOCK_THRESHOLD = 13'd2;

    // Shift steps of the weight divider; the top quotient bit comes from the
    // initial compare, so the quotient has DIV_STEPS + 1 bits.
    localparam int DIV_STEPS = 15;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [2:0] {
        CFG_ROBOT_RADIUS  = 3'd0,
        CFG_MAX_DETECTION = 3'd1,
        CFG_MIN_DETECTION = 3'd2,
        CFG_DYNAMIC_DEPTH = 3'd3,
        CFG_MAX_OBSTACLE  = 3'd4,
        CFG_BLIND_HALF    = 3'd5
    } cfg_idx_e;

    typedef struct packed {
        logic [15:0]        range_mm;
        logic signed [15:0] bearing_cdeg;
        logic signed [15:0] point_x_mm;
        logic signed [15:0] point_y_mm;
        logic signed [15:0] speed_fraction;
        logic               last_point;
    } point_t;

    typedef struct packed {
        logic               path_blocked;
        logic [12:0]        hit_count;
        logic [15:0]        nearest_range_mm;
        logic signed [15:0] nearest_bearing_cdeg;
        logic [15:0]        proximity_weight;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV_INIT,
        ST_DIV,
        ST_DONE
    } state_e;

    typedef struct packed {
        logic capture;
        logic eval;
        logic div_init;
        logic div_step;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic last_point;
    } status_t;

endpackage

// File: rtl/lsoc_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for scan points and scan results.
interface lsoc_point_if;
    logic             valid;
    logic             ready;
    lsoc_pkg::point_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lsoc_result_if;
    logic              valid;
    logic              ready;
    lsoc_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/lsoc_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: point handshake, divider sequencing, result slot.
module lsoc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  lsoc_pkg::status_t status,
    output lsoc_pkg::cmd_t    cmd
);

    lsoc_pkg::state_e               state_reg, state_next;
    logic [lsoc_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsoc_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            lsoc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = lsoc_pkg::ST_EVAL;
                end
            end
            lsoc_pkg::ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = status.last_point ? lsoc_pkg::ST_DIV_INIT : lsoc_pkg::ST_IDLE;
            end
            lsoc_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = lsoc_pkg::DIV_CNT_W'(lsoc_pkg::DIV_STEPS - 1);
                state_next   = lsoc_pkg::ST_DIV;
            end
            lsoc_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = lsoc_pkg::ST_DONE;
                end
            end
            lsoc_pkg::ST_DONE:
            begin
                // Hand over once the result slot is empty or being emptied.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = lsoc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsoc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_result)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/lsoc_datapath.sv
`timescale 1ns / 1ps
// Datapath: config registers, per-point hit and nearest tracking, weight divider.
module lsoc_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data,
    input  lsoc_pkg::point_t  in_point,
    input  lsoc_pkg::cmd_t    cmd,
    output lsoc_pkg::status_t status,
    output lsoc_pkg::result_t result
);

    // Configuration
    logic [15:0] radius_reg;
    logic [15:0] max_det_reg;
    logic [15:0] min_det_reg;
    logic        dyn_en_reg;
    logic [15:0] max_obs_reg;
    logic [9:0]  blind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= 16'd300;
            max_det_reg <= 16'd1500;
            min_det_reg <= 16'd500;
            dyn_en_reg  <= 1'b0;
            max_obs_reg <= 16'd1500;
            blind_reg   <= 10'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lsoc_pkg::CFG_ROBOT_RADIUS:  radius_reg  <= cfg_data;
                lsoc_pkg::CFG_MAX_DETECTION: max_det_reg <= cfg_data;
                lsoc_pkg::CFG_MIN_DETECTION: min_det_reg <= cfg_data;
                lsoc_pkg::CFG_DYNAMIC_DEPTH: dyn_en_reg  <= cfg_data[0];
                lsoc_pkg::CFG_MAX_OBSTACLE:  max_obs_reg <= cfg_data;
                lsoc_pkg::CFG_BLIND_HALF:    blind_reg   <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // Captured point and speed-scaled depth product
    lsoc_pkg::point_t   pt_reg;
    logic signed [31:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pt_reg   <= in_point;
            prod_reg <= $signed({{16{in_point.speed_fraction[15]}}, in_point.speed_fraction})
                        * $signed({16'd0, max_det_reg});
        end
    end

    assign status.last_point = pt_reg.last_point;

    // Scan state
    logic [lsoc_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [12:0]                hits_reg, hits_next;
    logic [15:0]                near_reg, near_next;
    logic [15:0]                bear_reg, bear_next;
    logic [15:0]                depth_reg, depth_next;

    logic        first;
    logic [15:0] depth_raw;
    logic [15:0] depth_calc;
    logic [15:0] near_base;
    logic [15:0] bear_base;
    logic [12:0] hits_base;
    logic        hit;
    logic [9:0]  win_lo;
    logic [10:0] win_hi;
    logic        in_window;

    assign first = (idx_reg == '0);

    always_comb
    begin
        if (dyn_en_reg)
        begin
            depth_raw = (!prod_reg[31] && prod_reg != '0) ? prod_reg[30:15] : 16'd0;
        end
        else
        begin
            depth_raw = max_det_reg;
        end
        depth_calc = (depth_raw < min_det_reg) ? min_det_reg : depth_raw;
    end

    always_comb
    begin
        depth_next = first ? depth_calc : depth_reg;
        near_base  = first ? max_obs_reg : near_reg;
        bear_base  = first ? 16'd0 : bear_reg;
        hits_base  = first ? 13'd0 : hits_reg;

        if (pt_reg.range_mm < radius_reg)
        begin
            hit = 1'b1;
        end
        else
        begin
            hit = !pt_reg.point_y_mm[15]
                && ($signed({pt_reg.point_y_mm[15], pt_reg.point_y_mm})
                    < $signed({1'b0, depth_next}))
                && ($signed({{2{pt_reg.point_x_mm[15]}}, pt_reg.point_x_mm})
                    >= -$signed({2'b00, radius_reg}))
                && ($signed({{2{pt_reg.point_x_mm[15]}}, pt_reg.point_x_mm})
                    < $signed({2'b00, radius_reg}));
        end
        hits_next = (hit && hits_base < lsoc_pkg::HIT_LIMIT) ? hits_base + 1'b1 : hits_base;

        // Frontal blind window, lower edge saturating at index zero
        win_lo    = (lsoc_pkg::FRONT_CENTER_INDEX >= blind_reg)
                    ? lsoc_pkg::FRONT_CENTER_INDEX - blind_reg : 10'd0;
        win_hi    = {1'b0, lsoc_pkg::FRONT_CENTER_INDEX} + {1'b0, blind_reg};
        in_window = (idx_reg >= lsoc_pkg::IDX_W'(win_lo))
                    && (lsoc_pkg::IDX_W'(win_hi) >= idx_reg);

        if (!in_window && pt_reg.range_mm < near_base)
        begin
            near_next = pt_reg.range_mm;
            bear_next = pt_reg.bearing_cdeg;
        end
        else
        begin
            near_next = near_base;
            bear_next = bear_base;
        end

        if (pt_reg.last_point)
        begin
            idx_next = '0;
        end
        else if (idx_reg != lsoc_pkg::LAST_INDEX)
        begin
            idx_next = idx_reg + 1'b1;
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else if (cmd.eval)
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            hits_reg  <= hits_next;
            near_reg  <= near_next;
            bear_reg  <= bear_next;
            depth_reg <= depth_next;
        end
    end

    // Restoring divider: (max - nearest) * 2^15 / max, one quotient bit a cycle.
    // A nearest range of zero gives the full weight: the top quotient bit is set
    // at init and the remainder starts at zero.
    logic [15:0]                    rem_reg;
    logic [lsoc_pkg::DIV_STEPS:0]   quot_reg;
    logic                           wzero_reg;
    logic [16:0]                    rem_shift;
    logic                           fits;

    assign rem_shift = {rem_reg, 1'b0};
    assign fits      = (rem_shift >= {1'b0, max_obs_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            wzero_reg <= !(max_obs_reg != 16'd0 && near_reg < max_obs_reg);
            rem_reg   <= (near_reg != 16'd0 && near_reg < max_obs_reg)
                         ? max_obs_reg - near_reg : 16'd0;
            quot_reg  <= {{lsoc_pkg::DIV_STEPS{1'b0}}, (near_reg == 16'd0)};
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= fits ? 16'(rem_shift - {1'b0, max_obs_reg}) : rem_shift[15:0];
            quot_reg <= {quot_reg[lsoc_pkg::DIV_STEPS-1:0], fits};
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_result)
        begin
            result.path_blocked         <= (hits_reg >= lsoc_pkg::BLOCK_THRESHOLD);
            result.hit_count            <= hits_reg;
            result.nearest_range_mm     <= near_reg;
            result.nearest_bearing_cdeg <= bear_reg;
            result.proximity_weight     <= wzero_reg ? 16'd0 : quot_reg;
        end
    end

endmodule

// File: rtl/laser_scan_obstacle_check_core.sv
`timescale 1ns / 1ps
// Top level of the laser scan obstacle check: controller plus datapath.
//
// Usage: scan points arrive one transaction at a time on the point channel
// (valid/ready), each with range, bearing, x/y in the robot frame, speed
// fraction and a last-point mark. The block counts platform and in-path hits,
// tracks the nearest range outside the frontal blind window, and on the last
// point of a scan sends one transaction on the result channel.
// Configuration goes through cfg_we/cfg_index/cfg_data; the user must write
// it only between scans while the block is idle, and the block itself does
// not enforce this. cfg_index follows the register list order.
// Points: each is captured, then evaluated, before the channel is ready again.
// Result: after the last point is accepted the block runs evaluate, divider
// init, the divider steps and hand-over, then loads the result register;
// hand-over waits while the result slot is full, and no point is taken
// while the restoring divider for the proximity weight runs.
// Stall: the result sits in an output register. The next scan streams in
// while it waits; only the next scan's final result holds until it is taken.
// Reset: configuration returns to its defaults, the point index goes to zero
// and the result channel drops valid.
module laser_scan_obstacle_check_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    lsoc_point_if.sink    point,
    lsoc_result_if.source result
);

    lsoc_pkg::cmd_t    cmd;
    lsoc_pkg::status_t status;

    lsoc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point.valid),
        .in_ready  (point.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .status    (status),
        .cmd       (cmd)
    );

    lsoc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_point  (point.payload),
        .cmd       (cmd),
        .status    (status),
        .result    (result.payload)
    );

endmodule
